// ----- rtl/core/ptes_pkg.sv -----
package ptes_pkg;

	localparam int PARTICLES = 1024;
	localparam int AXES      = 3;
	localparam int ADDR_W    = $clog2(PARTICLES * AXES);
	localparam int VAL_W     = 48;
	localparam int ENTRY_W   = 3 * VAL_W;

	localparam logic signed [VAL_W-1:0] MAX_VAL = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] MIN_VAL = {1'b1, {(VAL_W-1){1'b0}}};

	typedef enum logic [1:0] {
		ACT_STEP     = 2'd0,
		ACT_LOAD_POS = 2'd1,
		ACT_LOAD_VEL = 2'd2,
		ACT_NONE     = 2'd3
	} action_t;

	typedef enum logic {
		CFG_TIME_STEP   = 1'b0,
		CFG_FORCE_SCALE = 1'b1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE, S_READ, S_DATA, S_MULV, S_DELTA, S_MULF, S_DIVGO, S_DIVW, S_VEL, S_WRITE
	} fsm_t;

	typedef struct packed {
		logic [1:0]               action;
		logic [9:0]               particle;
		logic signed [VAL_W-1:0]  value_x;
		logic signed [VAL_W-1:0]  value_y;
		logic signed [VAL_W-1:0]  value_z;
		logic [46:0]              mass;
		logic                     fix_x;
		logic                     fix_y;
		logic                     fix_z;
	} item_t;

	typedef struct packed {
		logic [9:0]               particle_out;
		logic signed [VAL_W-1:0]  coord_x;
		logic signed [VAL_W-1:0]  coord_y;
		logic signed [VAL_W-1:0]  coord_z;
		logic signed [VAL_W-1:0]  delta_x;
		logic signed [VAL_W-1:0]  delta_y;
		logic signed [VAL_W-1:0]  delta_z;
		logic signed [VAL_W-1:0]  speed_x;
		logic signed [VAL_W-1:0]  speed_y;
		logic signed [VAL_W-1:0]  speed_z;
		logic                     overflow;
	} result_t;

	// Saturate a 50-bit sum to 48 bits; the top bit of the result is the clamp flag.
	function automatic logic [VAL_W:0] sat48(input logic signed [VAL_W+1:0] v);
		logic [VAL_W:0] r;
		if (v > (VAL_W+2)'(MAX_VAL)) begin
			r = {1'b1, MAX_VAL};
		end else if (v < (VAL_W+2)'(MIN_VAL)) begin
			r = {1'b1, MIN_VAL};
		end else begin
			r = {1'b0, v[VAL_W-1:0]};
		end
		return r;
	endfunction

	function automatic logic [VAL_W-1:0] mag48(input logic signed [VAL_W-1:0] v);
		return v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
	endfunction

endpackage

// ----- rtl/core/ptes_div.sv -----
module ptes_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [95:0] num,
	input  logic [62:0] den,
	output logic        done,
	output logic [48:0] quo
);
	localparam logic [48:0] CLIP = 49'h1_0000_0000_0000;

	logic        run_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [62:0] rem_q;
	logic [62:0] den_q;
	logic [48:0] low_q;
	logic [48:0] q_q;
	logic [63:0] trial;
	logic        ge;

	assign trial = {rem_q, low_q[48]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				// A quotient of 2^49 or more is clipped right away.
				if ({16'b0, num[95:49]} >= den) begin
					done_q <= 1'b1;
				end else begin
					run_q <= 1'b1;
					cnt_q <= 6'd48;
				end
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			den_q <= den;
			rem_q <= 63'(num[95:49]);
			low_q <= num[48:0];
			q_q   <= ({16'b0, num[95:49]} >= den) ? CLIP : '0;
		end else if (run_q) begin
			rem_q <= ge ? 63'(trial - {1'b0, den_q}) : trial[62:0];
			low_q <= {low_q[47:0], 1'b0};
			q_q   <= {q_q[47:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = (q_q > CLIP) ? CLIP : q_q;

endmodule

// ----- rtl/core/particle_translation_euler_step_top.sv -----
// A load item reads, sets and writes back each axis in turn. A step item multiplies the
// time step by the velocity on each axis and, where the velocity is updated, multiplies
// once more and runs a 49-step divide, which ends at once when the quotient clips. No
// new item is taken until the last axis of the current one is written.
// Reset is asynchronous and active low; it clears control, returns the configuration
// registers to their defaults and leaves the particle store undefined until written.
module particle_translation_euler_step_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  ptes_pkg::item_t     item,
	output logic                result_valid,
	output ptes_pkg::result_t   result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [31:0]         cfg_data
);
	import ptes_pkg::*;

	// Control and configuration state.
	fsm_t        state_q, state_d;
	logic [31:0] ts_q;
	logic [16:0] fs_q;
	logic [48:0] tf_q;
	logic [1:0]  axis_q;
	logic        flag_q;
	logic        valid_q;
	item_t       item_q;

	// Working registers for the entry being processed.
	logic signed [VAL_W-1:0] st_q, dp_q, vl_q;
	logic [48:0]             mula_q;
	logic [VAL_W-1:0]        mulb_q;
	logic [96:0]             acc_q;
	logic [1:0]              cnt_q;
	logic signed [VAL_W-1:0] coord_q [AXES];
	logic signed [VAL_W-1:0] delta_q [AXES];
	logic signed [VAL_W-1:0] speed_q [AXES];

	// The particle store: one entry per particle and axis holding start, displacement
	// and velocity side by side, so every axis is one read and one write.
	logic [ENTRY_W-1:0] mem [PARTICLES*AXES];
	logic [ENTRY_W-1:0] rdata_q;
	logic [ADDR_W-1:0]  addr;
	logic               mem_we;

	logic                    accept;
	logic                    in_range;
	logic signed [VAL_W-1:0] val;
	logic                    fix;
	logic                    upd;
	logic signed [VAL_W-1:0] rd_st, rd_dp, rd_vl;
	logic [64:0]             pp;
	logic [96:0]             pp_sh;
	logic [46:0]             mprod;
	logic signed [VAL_W-1:0] dval;
	logic [VAL_W:0]          dp_sat, vl_sat, co_sat;
	logic                    div_done;
	logic [48:0]             div_q;

	assign in_range = 32'(item.particle) < 32'(PARTICLES);
	assign accept   = start && (state_q == S_IDLE);
	assign busy     = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	assign addr = ADDR_W'({item_q.particle, 1'b0}) + ADDR_W'(item_q.particle) + ADDR_W'(axis_q);

	always_comb begin
		unique case (axis_q)
			2'd0:    begin val = item_q.value_x; fix = item_q.fix_x; end
			2'd1:    begin val = item_q.value_y; fix = item_q.fix_y; end
			default: begin val = item_q.value_z; fix = item_q.fix_z; end
		endcase
	end

	// A velocity update happens only on a free axis with a nonzero mass.
	assign upd = !fix && (item_q.mass != '0);

	assign {rd_st, rd_dp, rd_vl} = rdata_q;

	// The shared multiplier takes 16 bits of its second operand per cycle.
	assign pp    = mula_q * mulb_q[15:0];
	assign pp_sh = {32'b0, pp} << {cnt_q, 4'b0};

	// delta = time_step * velocity, truncated toward zero.
	assign mprod = acc_q[78:32];
	assign dval  = vl_q[VAL_W-1] ? -$signed({1'b0, mprod}) : $signed({1'b0, mprod});

	assign dp_sat = sat48((VAL_W+2)'(dp_q) + (VAL_W+2)'(dval));
	assign vl_sat = val[VAL_W-1] ? sat48((VAL_W+2)'(vl_q) - $signed({1'b0, div_q}))
	                             : sat48((VAL_W+2)'(vl_q) + $signed({1'b0, div_q}));
	assign co_sat = sat48((VAL_W+2)'(st_q) + (VAL_W+2)'(dp_q));

	ptes_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (state_q == S_DIVGO),
		.num    (acc_q[95:0]),
		.den    ({item_q.mass, 16'b0}),
		.done   (div_done),
		.quo    (div_q)
	);

	always_comb begin
		state_d = state_q;
		mem_we  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && in_range && (action_t'(item.action) != ACT_NONE)) begin
					state_d = S_READ;
				end
			end
			S_READ:  state_d = S_DATA;
			S_DATA: begin
				state_d = (action_t'(item_q.action) == ACT_STEP) ? S_MULV : S_WRITE;
			end
			S_MULV:  if (cnt_q == 2'd2) state_d = S_DELTA;
			S_DELTA: state_d = upd ? S_MULF : S_WRITE;
			S_MULF:  if (cnt_q == 2'd2) state_d = S_DIVGO;
			S_DIVGO: state_d = S_DIVW;
			S_DIVW:  if (div_done) state_d = S_VEL;
			S_VEL:   state_d = S_WRITE;
			S_WRITE: begin
				mem_we  = 1'b1;
				state_d = (axis_q == 2'd2) ? S_IDLE : S_READ;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ts_q    <= 32'd4295;
			fs_q    <= 17'd65536;
			tf_q    <= '0;
			valid_q <= 1'b0;
			axis_q  <= '0;
			cnt_q   <= '0;
			flag_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			tf_q    <= ts_q * fs_q;
			valid_q <= (state_q == S_WRITE) && (axis_q == 2'd2);
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_TIME_STEP:   ts_q <= cfg_data;
					CFG_FORCE_SCALE: fs_q <= cfg_data[16:0];
				endcase
			end
			if (accept) begin
				axis_q <= '0;
				flag_q <= (action_t'(item.action) == ACT_STEP) && (item.mass == '0);
			end
			if (state_q == S_DATA || state_q == S_DELTA) begin
				cnt_q <= '0;
			end else if (state_q == S_MULV || state_q == S_MULF) begin
				cnt_q <= cnt_q + 2'd1;
			end
			if (state_q == S_DELTA && dp_sat[VAL_W]) flag_q <= 1'b1;
			if (state_q == S_VEL && vl_sat[VAL_W]) flag_q <= 1'b1;
			if (state_q == S_WRITE) begin
				if (co_sat[VAL_W]) flag_q <= 1'b1;
				axis_q <= axis_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
			for (int k = 0; k < AXES; k++) begin
				delta_q[k] <= '0;
			end
		end
		unique case (state_q)
			S_DATA: begin
				st_q   <= rd_st;
				dp_q   <= rd_dp;
				vl_q   <= rd_vl;
				mula_q <= 49'(ts_q);
				mulb_q <= mag48(rd_vl);
				acc_q  <= '0;
				if (action_t'(item_q.action) == ACT_LOAD_POS) begin
					st_q <= val;
					dp_q <= '0;
				end else if (action_t'(item_q.action) == ACT_LOAD_VEL) begin
					vl_q <= val;
				end
			end
			S_MULV, S_MULF: begin
				acc_q  <= acc_q + pp_sh;
				mulb_q <= {16'b0, mulb_q[VAL_W-1:16]};
			end
			S_DELTA: begin
				dp_q            <= dp_sat[VAL_W-1:0];
				delta_q[axis_q] <= dval;
				mula_q          <= tf_q;
				mulb_q          <= mag48(val);
				acc_q           <= '0;
			end
			S_VEL: vl_q <= vl_sat[VAL_W-1:0];
			S_WRITE: begin
				coord_q[axis_q] <= co_sat[VAL_W-1:0];
				speed_q[axis_q] <= vl_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr] <= {st_q, dp_q, vl_q};
		end
		rdata_q <= mem[addr];
	end

	assign result_valid = valid_q;
	always_comb begin
		result.particle_out = item_q.particle;
		result.coord_x      = coord_q[0];
		result.coord_y      = coord_q[1];
		result.coord_z      = coord_q[2];
		result.delta_x      = delta_q[0];
		result.delta_y      = delta_q[1];
		result.delta_z      = delta_q[2];
		result.speed_x      = speed_q[0];
		result.speed_y      = speed_q[1];
		result.speed_z      = speed_q[2];
		result.overflow     = flag_q;
	end

endmodule

// ----- rtl/core/ptes_chk.sv -----
module ptes_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input ptes_pkg::item_t   item,
	input logic              result_valid
);
	import ptes_pkg::*;

	// Two results can never come in adjacent cycles.
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("back to back result strobes");

	// A result is shown only once the block has gone idle.
	a_idle_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy) else $error("result while busy");

	// A result always closes a busy period.
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy)) else $error("result without work");

	// A valid item that is transferred makes the block busy.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (item.action != ACT_NONE) && (32'(item.particle) < 32'(PARTICLES)))
		|=> busy) else $error("accepted item not started");

endmodule

bind particle_translation_euler_step_top ptes_chk u_ptes_chk (.*);

// ----- bench/tb.sv -----
module tb;
	import ptes_pkg::*;

	// Clock, reset and the ports of the block.
	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	item_t       item;
	logic        result_valid;
	result_t     result;
	logic        cfg_valid;
	logic        cfg_ready;
	cfg_idx_t    cfg_index;
	logic [31:0] cfg_data;

	localparam longint HI48 = 64'sd140737488355327;
	localparam longint LO48 = -64'sd140737488355328;
	localparam int     STALL_LIMIT = 4000;
	localparam int     DRAIN_WAIT  = 250;

	particle_translation_euler_step_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Items waiting to be offered, and the results that accepted items must produce.
	item_t   pending_items[$];
	result_t due_results[$];
	bit      due_speed_known[$];

	// Our own copy of the particle store and of the two registers.
	longint      start_pos[PARTICLES*AXES];
	longint      disp_acc[PARTICLES*AXES];
	longint      vel_st[PARTICLES*AXES];
	bit          vel_written[PARTICLES];
	logic [31:0] step_len;
	logic [16:0] force_gain;

	int  error_count;
	bit  steady_drive;   // when set, the driver offers items back to back
	int  quiet_cycles;

	// Which particles the stimulus has already loaded, so that no undefined entry is read.
	bit  gen_pos[PARTICLES];
	bit  gen_vel[PARTICLES];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic longint clamp48(input longint x, inout bit flag);
		if (x > HI48) begin
			flag = 1'b1;
			return HI48;
		end
		if (x < LO48) begin
			flag = 1'b1;
			return LO48;
		end
		return x;
	endfunction

	function automatic longint abs64(input longint x);
		return (x < 0) ? -x : x;
	endfunction

	// Forward Euler update of one particle; pushes the result the block must report.
	function automatic void predict_particle(input item_t it);
		result_t     r;
		longint      val[3];
		bit          fix[3];
		longint      dl[3];
		longint      crd[3];
		longint      v;
		logic [127:0] prod;
		logic [127:0] quot;
		logic [127:0] den;
		bit          flag;
		int          e;
		if (it.action == ACT_NONE)
			return;
		val[0] = longint'($signed(it.value_x));
		val[1] = longint'($signed(it.value_y));
		val[2] = longint'($signed(it.value_z));
		fix[0] = it.fix_x;
		fix[1] = it.fix_y;
		fix[2] = it.fix_z;
		flag = 1'b0;
		for (int k = 0; k < AXES; k++) begin
			e = it.particle * AXES + k;
			dl[k] = 0;
			case (it.action)
				ACT_LOAD_POS: begin
					start_pos[e] = val[k];
					disp_acc[e] = 0;
				end
				ACT_LOAD_VEL: begin
					vel_st[e] = val[k];
				end
				default: begin
					v = vel_st[e];
					prod = 128'(step_len) * 128'(abs64(v));
					dl[k] = longint'(prod >> 32);
					if (v < 0)
						dl[k] = -dl[k];
					disp_acc[e] = clamp48(disp_acc[e] + dl[k], flag);
					if (!fix[k] && it.mass != 0) begin
						prod = 128'(64'(step_len) * 64'(force_gain)) * 128'(abs64(val[k]));
						den = 128'(it.mass) << 16;
						quot = prod / den;
						if (quot > (128'd1 << 48))
							quot = 128'd1 << 48;
						v = (val[k] < 0) ? v - longint'(quot) : v + longint'(quot);
						vel_st[e] = clamp48(v, flag);
					end
				end
			endcase
		end
		if (it.action == ACT_STEP && it.mass == 0)
			flag = 1'b1;
		for (int k = 0; k < AXES; k++) begin
			e = it.particle * AXES + k;
			crd[k] = clamp48(start_pos[e] + disp_acc[e], flag);
		end
		e = it.particle * AXES;
		r.particle_out = it.particle;
		r.coord_x  = crd[0][47:0];
		r.coord_y  = crd[1][47:0];
		r.coord_z  = crd[2][47:0];
		r.delta_x  = dl[0][47:0];
		r.delta_y  = dl[1][47:0];
		r.delta_z  = dl[2][47:0];
		r.speed_x  = vel_st[e][47:0];
		r.speed_y  = vel_st[e+1][47:0];
		r.speed_z  = vel_st[e+2][47:0];
		r.overflow = flag;
		// A first position load reports a velocity that was never written, so it is not checked.
		if (it.action == ACT_LOAD_VEL)
			vel_written[it.particle] = 1'b1;
		due_speed_known.push_back(vel_written[it.particle]);
		due_results.push_back(r);
	endfunction

	// Driver: an item transfers at an edge with start high and busy low. A held offer stays.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item  <= '0;
		end else if (!start || !busy) begin
			if (start)
				predict_particle(item);
			if (pending_items.size() > 0 && (steady_drive || $urandom_range(99) >= 33)) begin
				start <= 1'b1;
				item  <= pending_items.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	task automatic check_field(input string name, input logic [47:0] got,
			input logic [47:0] want);
		if (got !== want)
			mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	// Monitor: every strobed result is matched against the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		bit      spd;
		if (arst_n && result_valid) begin
			if (due_results.size() == 0) begin
				mismatch($sformatf("result for particle %0d with none expected",
					result.particle_out));
			end else begin
				want = due_results.pop_front();
				spd  = due_speed_known.pop_front();
				check_field("particle_out", 48'(result.particle_out), 48'(want.particle_out));
				check_field("coord_x", result.coord_x, want.coord_x);
				check_field("coord_y", result.coord_y, want.coord_y);
				check_field("coord_z", result.coord_z, want.coord_z);
				check_field("delta_x", result.delta_x, want.delta_x);
				check_field("delta_y", result.delta_y, want.delta_y);
				check_field("delta_z", result.delta_z, want.delta_z);
				if (spd) begin
					check_field("speed_x", result.speed_x, want.speed_x);
					check_field("speed_y", result.speed_y, want.speed_y);
					check_field("speed_z", result.speed_z, want.speed_z);
				end
				check_field("overflow", 48'(result.overflow), 48'(want.overflow));
			end
		end
	end

	// Watchdog: any transfer or result counts as progress; a long silence ends the run.
	always @(posedge clk) begin
		if (!arst_n || result_valid || (start && !busy) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// A 48-bit value drawn from the extremes, zero, small fractions and full range.
	function automatic logic [47:0] pick_value();
		logic [63:0] raw;
		int          sel;
		raw = {$urandom, $urandom};
		sel = $urandom_range(99);
		if (sel < 10)
			return 48'h7fff_ffff_ffff;
		if (sel < 20)
			return 48'h8000_0000_0000;
		if (sel < 27)
			return 48'h0;
		if (sel < 60)
			return 48'($signed(raw[31:0])) <<< $urandom_range(16);
		return raw[47:0];
	endfunction

	function automatic logic [46:0] pick_mass();
		int sel;
		sel = $urandom_range(99);
		if (sel < 10)
			return 47'h0;
		if (sel < 25)
			return 47'($urandom_range(16, 1));
		if (sel < 65)
			return {7'($urandom_range(127)), 8'($urandom_range(255, 1)), 32'($urandom)};
		return 47'({$urandom, $urandom});
	endfunction

	function automatic item_t make_item(input action_t act, input int p);
		item_t it;
		it.action   = act;
		it.particle = 10'(p);
		it.value_x  = pick_value();
		it.value_y  = pick_value();
		it.value_z  = pick_value();
		it.mass     = pick_mass();
		it.fix_x    = 1'($urandom_range(1));
		it.fix_y    = 1'($urandom_range(1));
		it.fix_z    = 1'($urandom_range(1));
		return it;
	endfunction

	function automatic item_t make_fixed(input action_t act, input int p,
			input logic [47:0] vx, input logic [47:0] vy, input logic [47:0] vz,
			input logic [46:0] m, input logic [2:0] fx);
		item_t it;
		it.action   = act;
		it.particle = 10'(p);
		it.value_x  = vx;
		it.value_y  = vy;
		it.value_z  = vz;
		it.mass     = m;
		{it.fix_x, it.fix_y, it.fix_z} = fx;
		if (act == ACT_LOAD_POS)
			gen_pos[p] = 1'b1;
		if (act == ACT_LOAD_VEL)
			gen_vel[p] = 1'b1;
		return it;
	endfunction

	// Random items: a fresh particle is loaded position first, then velocity, then stepped.
	task automatic queue_random(input int count);
		int     done;
		int     p;
		int     sel;
		action_t act;
		done = 0;
		while (done < count) begin
			sel = $urandom_range(99);
			if (sel < 70)
				p = $urandom_range(7);
			else if (sel < 90)
				p = $urandom_range(PARTICLES - 1);
			else
				p = $urandom_range(1) ? PARTICLES - 1 : 0;
			sel = $urandom_range(99);
			if (!gen_pos[p])
				act = ACT_LOAD_POS;
			else if (!gen_vel[p])
				act = ACT_LOAD_VEL;
			else if (sel < 60)
				act = ACT_STEP;
			else if (sel < 75)
				act = ACT_LOAD_POS;
			else if (sel < 90)
				act = ACT_LOAD_VEL;
			else
				act = ACT_NONE;
			if (act == ACT_LOAD_POS)
				gen_pos[p] = 1'b1;
			if (act == ACT_LOAD_VEL)
				gen_vel[p] = 1'b1;
			pending_items.push_back(make_item(act, p));
			if (act != ACT_NONE)
				done++;
		end
	endtask

	// Waits until every queued item has transferred and every result has come, then
	// lets the block finish anything that produces no result.
	task automatic drain();
		while (pending_items.size() > 0 || start || due_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_TIME_STEP)
			step_len = data;
		else
			force_gain = data[16:0];
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_TIME_STEP;
		cfg_data     = '0;
		error_count  = 0;
		steady_drive = 1'b0;
		quiet_cycles = 0;
		step_len     = 32'd4295;
		force_gain   = 17'd65536;
		for (int i = 0; i < PARTICLES * AXES; i++) begin
			start_pos[i] = 0;
			disp_acc[i]  = 0;
			vel_st[i]    = 0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part with the reset register values: extreme loads, zero mass,
		// fixed axes, saturation of coordinates and velocity, and an ignored action.
		pending_items.push_back(make_fixed(ACT_LOAD_POS, 0, 48'h7fff_ffff_ffff,
			48'h8000_0000_0000, 48'h0, 47'h0, 3'b000));
		pending_items.push_back(make_fixed(ACT_LOAD_VEL, 0, 48'h7fff_ffff_ffff,
			48'h8000_0000_0000, 48'h1_0000_0000, 47'h0, 3'b000));
		pending_items.push_back(make_fixed(ACT_STEP, 0, 48'h1_0000_0000,
			48'h8000_0000_0000, 48'h7fff_ffff_ffff, 47'h0, 3'b000));
		pending_items.push_back(make_fixed(ACT_STEP, 0, 48'h7fff_ffff_ffff,
			48'h8000_0000_0000, 48'hffff_0000_0000, 47'h1, 3'b000));
		pending_items.push_back(make_fixed(ACT_STEP, 0, 48'h7fff_ffff_ffff,
			48'h8000_0000_0000, 48'h7fff_ffff_ffff, 47'h1, 3'b101));
		pending_items.push_back(make_fixed(ACT_LOAD_POS, PARTICLES - 1, 48'h8000_0000_0000,
			48'h7fff_ffff_ffff, 48'hffff_ffff_ffff, 47'h7fff_ffff_ffff, 3'b111));
		pending_items.push_back(make_fixed(ACT_LOAD_VEL, PARTICLES - 1, 48'h8000_0000_0000,
			48'h0, 48'h7fff_ffff_ffff, 47'h7fff_ffff_ffff, 3'b111));
		pending_items.push_back(make_fixed(ACT_STEP, PARTICLES - 1, 48'h0,
			48'h0, 48'h0, 47'h7fff_ffff_ffff, 3'b000));
		pending_items.push_back(make_fixed(ACT_STEP, PARTICLES - 1, 48'h7fff_ffff_ffff,
			48'h8000_0000_0000, 48'h1, 47'h7fff_ffff_ffff, 3'b010));
		pending_items.push_back(make_fixed(ACT_NONE, 5, 48'h1, 48'h2, 48'h3,
			47'h1_0000_0000, 3'b000));
		pending_items.push_back(make_fixed(ACT_LOAD_POS, 1, 48'h0, 48'h0, 48'h0,
			47'h0, 3'b000));
		pending_items.push_back(make_fixed(ACT_LOAD_VEL, 1, 48'h0, 48'h0, 48'h0,
			47'h0, 3'b000));
		pending_items.push_back(make_fixed(ACT_STEP, 1, 48'h1_0000_0000,
			48'hffff_0000_0000, 48'h0, 47'h1_0000_0000, 3'b000));
		pending_items.push_back(make_fixed(ACT_STEP, 1, 48'h1_0000_0000,
			48'hffff_0000_0000, 48'h0, 47'h1_0000_0000, 3'b000));
		pending_items.push_back(make_fixed(ACT_LOAD_POS, 0, 48'h0, 48'h0, 48'h0,
			47'h0, 3'b000));
		queue_random(200);
		drain();

		// Smallest time step with the force switched off.
		write_reg(CFG_TIME_STEP, 32'd1);
		write_reg(CFG_FORCE_SCALE, 32'd0);
		queue_random(250);
		drain();

		// Largest time step and force scale, where saturation is common.
		write_reg(CFG_TIME_STEP, 32'hffff_ffff);
		write_reg(CFG_FORCE_SCALE, 32'd131071);
		queue_random(250);
		drain();

		// A hundredth of a second at unit force, offered back to back.
		write_reg(CFG_TIME_STEP, 32'd42949673);
		write_reg(CFG_FORCE_SCALE, 32'd65536);
		steady_drive = 1'b1;
		queue_random(250);
		drain();
		steady_drive = 1'b0;

		write_reg(CFG_TIME_STEP, $urandom_range(32'hffff_ffff, 1));
		write_reg(CFG_FORCE_SCALE, $urandom_range(65536));
		queue_random(250);
		drain();

		write_reg(CFG_TIME_STEP, 32'hffff_ffff);
		write_reg(CFG_FORCE_SCALE, 32'd65536);
		queue_random(250);
		drain();

		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
